FILE: rtl/alb_pkg.sv
// ----------------------------------------------------------------------------
// alb_pkg
// Shared types, constants and the brightness gain table for the addressable
// LED bit encoder.
// ----------------------------------------------------------------------------
package alb_pkg;

  // slots emitted per led, green first, msb first
  localparam int BITS_PER_LED = 24;
  localparam int CNT_W        = $clog2(BITS_PER_LED + 1);
  localparam int LEVEL_W      = 8;
  localparam int GAIN_W       = 16;
  localparam int GAIN_SHIFT   = 15;
  localparam int BRIGHT_W     = 6;
  localparam int CFG_W        = 8;
  localparam int CFG_IDX_W    = 2;

  localparam logic [BRIGHT_W-1:0] MAX_BRIGHTNESS = BRIGHT_W'(45);
  localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS = BRIGHT_W'(22);
  localparam logic [7:0]          RST_ONE_DUTY   = 8'd68;
  localparam logic [7:0]          RST_ZERO_DUTY  = 8'd32;
  localparam logic [7:0]          RST_GAP_SLOTS  = 8'd48;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_ONE_DUTY   = 2'd1,
    REG_ZERO_DUTY  = 2'd2,
    REG_GAP_SLOTS  = 2'd3
  } cfg_reg_t;

  // serialiser phases
  typedef enum logic [1:0] {
    SER_IDLE,
    SER_DATA,
    SER_GAP
  } ser_state_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       final_led;
  } led_word_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [7:0] repeat_res;
    logic       run_end;
  } slot_word_t;

  // duty settings handed to the serialiser
  typedef struct packed {
    logic [7:0] one_duty;
    logic [7:0] zero_duty;
    logic [7:0] gap_slots;
  } duty_cfg_t;

  // round(tan(b deg) * 32768), unsigned q1.15
  function automatic logic [GAIN_W-1:0] gain_lookup(input logic [BRIGHT_W-1:0] b);
    logic [GAIN_W-1:0] g;
    unique case (b)
      6'd0:  g = 16'd0;     6'd1:  g = 16'd572;   6'd2:  g = 16'd1144;
      6'd3:  g = 16'd1717;  6'd4:  g = 16'd2291;  6'd5:  g = 16'd2867;
      6'd6:  g = 16'd3444;  6'd7:  g = 16'd4023;  6'd8:  g = 16'd4605;
      6'd9:  g = 16'd5190;  6'd10: g = 16'd5778;  6'd11: g = 16'd6369;
      6'd12: g = 16'd6965;  6'd13: g = 16'd7565;  6'd14: g = 16'd8170;
      6'd15: g = 16'd8780;  6'd16: g = 16'd9396;  6'd17: g = 16'd10018;
      6'd18: g = 16'd10647; 6'd19: g = 16'd11283; 6'd20: g = 16'd11927;
      6'd21: g = 16'd12578; 6'd22: g = 16'd13239; 6'd23: g = 16'd13909;
      6'd24: g = 16'd14589; 6'd25: g = 16'd15280; 6'd26: g = 16'd15982;
      6'd27: g = 16'd16696; 6'd28: g = 16'd17423; 6'd29: g = 16'd18164;
      6'd30: g = 16'd18919; 6'd31: g = 16'd19689; 6'd32: g = 16'd20476;
      6'd33: g = 16'd21280; 6'd34: g = 16'd22102; 6'd35: g = 16'd22944;
      6'd36: g = 16'd23807; 6'd37: g = 16'd24692; 6'd38: g = 16'd25601;
      6'd39: g = 16'd26535; 6'd40: g = 16'd27496; 6'd41: g = 16'd28485;
      6'd42: g = 16'd29504; 6'd43: g = 16'd30557; 6'd44: g = 16'd31644;
      default: g = 16'd32768;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/alb_lane.sv
// ----------------------------------------------------------------------------
// alb_lane
// One colour lane: scales a level by the q1.15 gain and registers the
// truncated byte.
// ----------------------------------------------------------------------------
module alb_lane (
  input  logic                       clk,
  input  logic                       load,
  input  logic [alb_pkg::LEVEL_W-1:0] level,
  input  logic [alb_pkg::GAIN_W-1:0]  gain,
  output logic [alb_pkg::LEVEL_W-1:0] scaled
);
  import alb_pkg::*;

  logic [LEVEL_W+GAIN_W-1:0] product;

  // level times gain, never above 255 after the shift
  assign product = {{GAIN_W{1'b0}}, level} * {{LEVEL_W{1'b0}}, gain};

  // scaled byte register
  always_ff @(posedge clk) begin
    if (load) begin
      scaled <= product[GAIN_SHIFT +: LEVEL_W];
    end
  end

endmodule

FILE: rtl/alb_ser.sv
// ----------------------------------------------------------------------------
// alb_ser
// Merging stage and slot serialiser: packs the three lane bytes into one
// grb word shifted out a slot per cycle unless stalled; a final led adds the gap.
// ----------------------------------------------------------------------------
module alb_ser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   lane_valid,
  input  logic                   lane_final,
  input  logic [7:0]             red_scaled,
  input  logic [7:0]             green_scaled,
  input  logic [7:0]             blue_scaled,
  input  alb_pkg::duty_cfg_t     duty_cfg,
  output logic                   load,
  output logic                   slot_valid,
  input  logic                   slot_stall,
  output alb_pkg::slot_word_t    slot_word
);
  import alb_pkg::*;

  ser_state_t              state, state_next;
  logic [BITS_PER_LED-1:0] shreg;
  logic [CNT_W-1:0]        cnt;
  logic                    fin;
  logic                    adv;
  logic                    last_res;
  logic                    free;
  logic [BITS_PER_LED-1:0] merged;
  slot_word_t              slot;

  // merge the lane bytes, green in the top byte
  assign merged = BITS_PER_LED'({green_scaled, red_scaled, blue_scaled});

  // output register can take a new slot
  assign adv = !slot_valid || !slot_stall;

  // this cycle ends the current led
  assign last_res = ((state == SER_DATA) && (cnt == CNT_W'(1)) && !fin) ||
                    (state == SER_GAP);
  assign free = (state == SER_IDLE) || (adv && last_res);
  assign load = lane_valid && free;

  // next phase
  always_comb begin
    state_next = state;
    unique case (state)
      SER_IDLE: begin
        if (load) state_next = SER_DATA;
      end
      SER_DATA: begin
        if (adv && (cnt == CNT_W'(1))) begin
          if (fin) state_next = SER_GAP;
          else if (load) state_next = SER_DATA;
          else state_next = SER_IDLE;
        end
      end
      SER_GAP: begin
        if (adv) state_next = load ? SER_DATA : SER_IDLE;
      end
      default: state_next = SER_IDLE;
    endcase
  end

  // slot produced in the current phase
  always_comb begin
    slot = '0;
    unique case (state)
      SER_DATA: begin
        slot.duty       = shreg[BITS_PER_LED-1] ? duty_cfg.one_duty : duty_cfg.zero_duty;
        slot.repeat_res = 8'd1;
        slot.run_end    = (cnt == CNT_W'(1)) && !fin;
      end
      SER_GAP: begin
        slot.duty       = 8'd0;
        slot.repeat_res = duty_cfg.gap_slots;
        slot.run_end    = 1'b1;
      end
      default: slot = '0;
    endcase
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SER_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shift register and slot count
  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= merged;
      cnt   <= CNT_W'(BITS_PER_LED);
      fin   <= lane_final;
    end else if (adv && (state == SER_DATA)) begin
      shreg <= {shreg[BITS_PER_LED-2:0], 1'b0};
      cnt   <= cnt - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (adv) begin
      slot_valid <= (state != SER_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot_word <= slot;
    end
  end

  // a new led is taken only when the serialiser finishes or is empty
  assert property (@(posedge clk) disable iff (rst)
    load |-> (state == SER_IDLE) || (adv && last_res))
    else $error("alb_ser: load while a led is still being sent");

  // data phase always has slots left
  assert property (@(posedge clk) disable iff (rst)
    (state == SER_DATA) |-> (cnt != '0))
    else $error("alb_ser: data phase with empty count");

  // a slot repeated more than once is the gap: zero duty, end of run
  assert property (@(posedge clk) disable iff (rst)
    (slot_valid && (slot_word.repeat_res != 8'd1)) |->
      (slot_word.duty == 8'd0) && slot_word.run_end)
    else $error("alb_ser: long slot that is not a gap");

  // a final led moves from data into the gap phase
  assert property (@(posedge clk) disable iff (rst)
    ((state == SER_DATA) && fin && adv && (cnt == CNT_W'(1))) |=> (state == SER_GAP))
    else $error("alb_ser: gap slot skipped after final led");

endmodule

FILE: rtl/addressable_led_bit_encoder.sv
// ----------------------------------------------------------------------------
// addressable_led_bit_encoder
// Scales an rgb led word by a tan() brightness gain and turns it into a
// stream of pwm duty slots, grb msb first, with a reset gap after the last led.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | word
//  led      | in        | led_valid/led_stall | led_word_t (r, g, b, final_led)
//  slot     | out       | slot_valid/slot_stall | slot_word_t (duty, repeat, end)
//  cfg      | in        | cfg_we              | cfg_index, cfg_data
//
//  a led is sent as 24 data slots, plus the gap slot when it is the last of the
//  chain; the serialiser emits one slot per cycle unless the slot side stalls.
//  a led word passes the lane registers, the serialiser shift register and the output register before its first slot.
//  the next led word is taken into the lane stage while the current one shifts.
//  reset is synchronous and restores the default register values.
//  stall on the slot side holds the output and back-pressures the led side.
// ----------------------------------------------------------------------------
module addressable_led_bit_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            led_valid,
  output logic                            led_stall,
  input  alb_pkg::led_word_t              led_word,
  output logic                            slot_valid,
  input  logic                            slot_stall,
  output alb_pkg::slot_word_t             slot_word,
  input  logic                            cfg_we,
  input  logic [alb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alb_pkg::CFG_W-1:0]       cfg_data
);
  import alb_pkg::*;

  logic [BRIGHT_W-1:0] brightness;
  duty_cfg_t           duty_cfg;
  logic [GAIN_W-1:0]   gain;
  logic                lane_valid;
  logic                lane_final;
  logic                led_take;
  logic                load;
  logic [7:0]          red_scaled;
  logic [7:0]          green_scaled;
  logic [7:0]          blue_scaled;
  cfg_reg_t            cfg_reg;

  assign cfg_reg = cfg_reg_t'(cfg_index);

  // configuration registers with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness         <= RST_BRIGHTNESS;
      duty_cfg.one_duty  <= RST_ONE_DUTY;
      duty_cfg.zero_duty <= RST_ZERO_DUTY;
      duty_cfg.gap_slots <= RST_GAP_SLOTS;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_BRIGHTNESS: begin
          brightness <= (cfg_data[BRIGHT_W-1:0] > MAX_BRIGHTNESS) ?
                        MAX_BRIGHTNESS : cfg_data[BRIGHT_W-1:0];
        end
        REG_ONE_DUTY:  duty_cfg.one_duty  <= cfg_data;
        REG_ZERO_DUTY: duty_cfg.zero_duty <= cfg_data;
        REG_GAP_SLOTS: duty_cfg.gap_slots <= (cfg_data == 8'd0) ? 8'd1 : cfg_data;
        default: ;
      endcase
    end
  end

  assign gain = gain_lookup(brightness);

  // lane stage handshake
  assign led_stall = lane_valid && !load;
  assign led_take  = led_valid && !led_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (led_take) begin
      lane_valid <= 1'b1;
    end else if (load) begin
      lane_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (led_take) begin
      lane_final <= led_word.final_led;
    end
  end

  // one scaling lane per colour
  alb_lane u_lane_red (
    .clk    (clk),
    .load   (led_take),
    .level  (led_word.red_level),
    .gain   (gain),
    .scaled (red_scaled)
  );

  alb_lane u_lane_green (
    .clk    (clk),
    .load   (led_take),
    .level  (led_word.green_level),
    .gain   (gain),
    .scaled (green_scaled)
  );

  alb_lane u_lane_blue (
    .clk    (clk),
    .load   (led_take),
    .level  (led_word.blue_level),
    .gain   (gain),
    .scaled (blue_scaled)
  );

  // merge and serialise
  alb_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .lane_valid   (lane_valid),
    .lane_final   (lane_final),
    .red_scaled   (red_scaled),
    .green_scaled (green_scaled),
    .blue_scaled  (blue_scaled),
    .duty_cfg     (duty_cfg),
    .load         (load),
    .slot_valid   (slot_valid),
    .slot_stall   (slot_stall),
    .slot_word    (slot_word)
  );

  // lane stage only back-pressures when it holds a word
  assert property (@(posedge clk) disable iff (rst)
    led_stall |-> lane_valid)
    else $error("encoder: stall with an empty lane stage");

  // brightness never leaves the table range
  assert property (@(posedge clk) disable iff (rst)
    brightness <= MAX_BRIGHTNESS)
    else $error("encoder: brightness above table range");

  // gap length is never zero
  assert property (@(posedge clk) disable iff (rst)
    duty_cfg.gap_slots != 8'd0)
    else $error("encoder: zero gap length");

endmodule
